[hw/rtl/assert_macros.svh]
// assertion macros used by the weight update unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLKED(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

[hw/rtl/mlpbp_pkg.sv]
// constants, types and fixed-point helpers for the weight update unit
`timescale 1ns / 1ps
package mlpbp_pkg;

  localparam int INPUT_WIDTH   = 64;
  localparam int HIDDEN_WIDTH  = 10;
  localparam int HIDDEN_LAYERS = 2;
  localparam int FRAC_BITS     = 16;

  localparam int DATA_W       = 32;
  localparam int STEP_W       = 17;
  localparam int CMD_W        = 3;
  localparam int LAYER_FLD_W  = 3;
  localparam int NODE_FLD_W   = 6;
  localparam int SLOT_FLD_W   = 4;
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(6554);

  localparam int W_DEPTH = INPUT_WIDTH * HIDDEN_WIDTH
                         + (HIDDEN_LAYERS - 1) * HIDDEN_WIDTH * HIDDEN_WIDTH + HIDDEN_WIDTH;
  localparam int B_DEPTH = (HIDDEN_LAYERS + 1) * HIDDEN_WIDTH;
  localparam int H_DEPTH = HIDDEN_LAYERS * HIDDEN_WIDTH;

  localparam int WA_W    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int BA_W    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int HA_W    = (H_DEPTH > 1) ? $clog2(H_DEPTH) : 1;
  localparam int IA_W    = (INPUT_WIDTH > 1) ? $clog2(INPUT_WIDTH) : 1;
  localparam int MAX_NODES = (INPUT_WIDTH > HIDDEN_WIDTH) ? INPUT_WIDTH : HIDDEN_WIDTH;
  localparam int NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int SLOT_W  = (HIDDEN_WIDTH > 1) ? $clog2(HIDDEN_WIDTH) : 1;
  localparam int LAYER_W = $clog2(HIDDEN_LAYERS + 1);

  localparam int OPA_W   = DATA_W + 1;
  localparam int PROD_W  = OPA_W + DATA_W;
  localparam int ACC_W   = DATA_W + SLOT_W + 1;

  localparam logic signed [DATA_W-1:0] Q_ONE = DATA_W'(1) << FRAC_BITS;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_WEIGHT = 3'd0,
    CMD_WR_BIAS   = 3'd1,
    CMD_IN_ACT    = 3'd2,
    CMD_HID_ACT   = 3'd3,
    CMD_NET_OUT   = 3'd4,
    CMD_TRAIN     = 3'd5,
    CMD_RD_WEIGHT = 3'd6,
    CMD_RD_BIAS   = 3'd7
  } cmd_e;

  typedef logic signed [PROD_W:0] wide_t;

  function automatic logic signed [DATA_W-1:0] sat_wide(input wide_t v);
    logic signed [DATA_W-1:0] r;
    if (v[PROD_W:DATA_W-1] == {(PROD_W + 2 - DATA_W){v[PROD_W]}}) begin
      r = v[DATA_W-1:0];
    end else if (v[PROD_W]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

  // add half an lsb, floor shift, clamp
  function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    wide_t t;
    t = (PROD_W+1)'(p) + ((PROD_W+1)'(1) <<< (FRAC_BITS - 1));
    return sat_wide(t >>> FRAC_BITS);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
    return sat_wide((PROD_W+1)'(a) + (PROD_W+1)'(b));
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
    return sat_wide((PROD_W+1)'(a) - (PROD_W+1)'(b));
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] a);
    return sat_wide((PROD_W+1)'(a));
  endfunction

  function automatic int layer_fanout(input int l);
    return (l < HIDDEN_LAYERS) ? HIDDEN_WIDTH : 1;
  endfunction

  function automatic int layer_nodes(input int l);
    return (l == 0) ? INPUT_WIDTH : HIDDEN_WIDTH;
  endfunction

  function automatic logic weight_ok(input int l, input int j, input int s);
    return (l <= HIDDEN_LAYERS) && (j < layer_nodes(l)) && (s < layer_fanout(l));
  endfunction

  function automatic logic bias_ok(input int l, input int s);
    return (l <= HIDDEN_LAYERS) && (s < layer_fanout(l));
  endfunction

  function automatic logic [WA_W-1:0] weight_addr(input int l, input int j, input int s);
    int base;
    base = (l == 0) ? 0
         : INPUT_WIDTH * HIDDEN_WIDTH + (l - 1) * HIDDEN_WIDTH * HIDDEN_WIDTH;
    return WA_W'(base + j * layer_fanout(l) + s);
  endfunction

endpackage

[hw/rtl/mlpbp_if.sv]
// item channels and the step size write channel
`timescale 1ns / 1ps
interface mlpbp_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [mlpbp_pkg::CMD_W-1:0]              cmd;
  logic [mlpbp_pkg::LAYER_FLD_W-1:0]        layer_index;
  logic [mlpbp_pkg::NODE_FLD_W-1:0]         node_index;
  logic [mlpbp_pkg::SLOT_FLD_W-1:0]         target_slot;
  logic signed [mlpbp_pkg::DATA_W-1:0]      data_word;
  modport source (output valid, cmd, layer_index, node_index, target_slot, data_word,
                  input ready);
  modport sink (input valid, cmd, layer_index, node_index, target_slot, data_word,
                output ready);
endinterface

interface mlpbp_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [mlpbp_pkg::DATA_W-1:0]      read_word;
  logic                                     train_done;
  modport source (output valid, read_word, train_done, input ready);
  modport sink (input valid, read_word, train_done, output ready);
endinterface

interface mlpbp_cfg_if;
  logic                                     valid;
  logic                                     ready;
  logic [mlpbp_pkg::STEP_W-1:0]             step_size;
  modport source (output valid, step_size, input ready);
  modport sink (input valid, step_size, output ready);
endinterface

[hw/rtl/mlpbp_qmul.sv]
// shared fixed-point multiplier: product stage, then round and clamp stage
`timescale 1ns / 1ps
module mlpbp_qmul (
  input  logic                                  clk_i,
  input  logic signed [mlpbp_pkg::OPA_W-1:0]    a_i,
  input  logic signed [mlpbp_pkg::DATA_W-1:0]   b_i,
  output logic signed [mlpbp_pkg::DATA_W-1:0]   q_o
);

  logic signed [mlpbp_pkg::PROD_W-1:0] prod_q;
  logic signed [mlpbp_pkg::DATA_W-1:0] q_q;

  // the product is registered in prod_q, then rounded and clamped into q_q
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    q_q    <= mlpbp_pkg::round_sat(prod_q);
  end

  assign q_o = q_q;

endmodule

[hw/rtl/mlp_backprop_weight_update_unit.sv]
// weight update unit: stores an mlp, runs one backprop training step per train item
//
//  channel   dir  handshake      payload
//  in_ch_i   in   valid/ready    cmd, layer_index, node_index, target_slot, data_word
//  out_ch_o  out  valid/ready    read_word, train_done
//  cfg_i     in   valid/ready    step_size (always ready)
//
// load items are written while idle; a read item passes through ST_RD_WAIT and ST_OUT
// to the output register. a train item first forms the output error, then per node
// updates each weight through the shared multiplier, forms hidden errors, updates the biases.
// rst_ni clears the sequencer, network output and error terms and sets the step size to STEP_RESET.
// the input is not ready while an item is at work; a waiting result does not block
// loads, and a finished read or train waits for the output register to free up.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mlp_backprop_weight_update_unit (
  input  logic  clk_i,
  input  logic  rst_ni,
  mlpbp_in_if.sink    in_ch_i,
  mlpbp_out_if.source out_ch_o,
  mlpbp_cfg_if.sink   cfg_i
);

  localparam int DW = mlpbp_pkg::DATA_W;
  localparam int HW = mlpbp_pkg::HIDDEN_WIDTH;
  localparam int HL = mlpbp_pkg::HIDDEN_LAYERS;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_WAIT, ST_OUT,
    ST_T_Y0, ST_T_Y1, ST_T_Y2, ST_T_Y3, ST_T_Y4,
    ST_N_ACT, ST_N_CAP,
    ST_W0, ST_W1, ST_W2, ST_W3, ST_W4,
    ST_E0, ST_E1, ST_E2, ST_E3, ST_E4,
    ST_B0, ST_B1, ST_B2
  } state_e;

  state_e state_q;
  logic [mlpbp_pkg::LAYER_W-1:0] layer_q;
  logic [mlpbp_pkg::NODE_W-1:0]  node_q;
  logic [mlpbp_pkg::SLOT_W-1:0]  slot_q;
  logic [mlpbp_pkg::STEP_W-1:0]  step_q;
  logic signed [DW-1:0] net_q, target_q, derr_q, act_q, res_word_q;
  logic signed [mlpbp_pkg::ACC_W-1:0] acc_q;
  logic signed [DW-1:0] err_q [mlpbp_pkg::H_DEPTH];
  logic res_done_q, rd_ok_q, rd_bias_q;
  logic out_valid_q, out_done_q;
  logic signed [DW-1:0] out_word_q;
  logic out_load;

  // memories
  logic signed [DW-1:0] w_mem   [mlpbp_pkg::W_DEPTH];
  logic signed [DW-1:0] b_mem   [mlpbp_pkg::B_DEPTH];
  logic signed [DW-1:0] in_mem  [mlpbp_pkg::INPUT_WIDTH];
  logic signed [DW-1:0] hid_mem [mlpbp_pkg::H_DEPTH];
  logic signed [DW-1:0] w_rd, b_rd, in_rd, hid_rd;
  logic [mlpbp_pkg::WA_W-1:0] w_addr;
  logic [mlpbp_pkg::BA_W-1:0] b_addr;
  logic [mlpbp_pkg::IA_W-1:0] in_addr;
  logic [mlpbp_pkg::HA_W-1:0] hid_addr;
  logic w_we, b_we, in_we, hid_we;
  logic signed [DW-1:0] w_wd, b_wd;

  logic signed [mlpbp_pkg::OPA_W-1:0] mul_a;
  logic signed [DW-1:0] mul_b, mq;

  logic in_acc;
  int   fl, fj, fs;
  logic signed [DW-1:0] next_val;
  logic signed [mlpbp_pkg::OPA_W-1:0] step_op;
  logic [mlpbp_pkg::SLOT_W-1:0] fan_m1;
  logic [mlpbp_pkg::NODE_W-1:0] nodes_m1;
  logic last_slot, last_node;

  assign in_acc = in_ch_i.valid && in_ch_i.ready;
  assign in_ch_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_ch_o.valid = out_valid_q;
  assign out_ch_o.read_word = out_word_q;
  assign out_ch_o.train_done = out_done_q;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ch_o.ready);

  assign fl = int'(in_ch_i.layer_index);
  assign fj = int'(in_ch_i.node_index);
  assign fs = int'(in_ch_i.target_slot);

  assign step_op  = $signed({{(mlpbp_pkg::OPA_W - mlpbp_pkg::STEP_W){1'b0}}, step_q});
  assign fan_m1   = mlpbp_pkg::SLOT_W'(mlpbp_pkg::layer_fanout(int'(layer_q)) - 1);
  assign nodes_m1 = mlpbp_pkg::NODE_W'(mlpbp_pkg::layer_nodes(int'(layer_q)) - 1);
  assign last_slot = (slot_q == fan_m1);
  assign last_node = (node_q == nodes_m1);

  // error of the next layer feeding this slot
  always_comb begin
    if (int'(layer_q) == HL) begin
      next_val = (slot_q == '0) ? derr_q : '0;
    end else begin
      next_val = err_q[mlpbp_pkg::HA_W'(int'(layer_q) * HW + int'(slot_q))];
    end
  end

  mlpbp_qmul u_qmul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .q_o   (mq)
  );

  always_comb begin
    w_we     = 1'b0;
    b_we     = 1'b0;
    in_we    = 1'b0;
    hid_we   = 1'b0;
    w_addr   = mlpbp_pkg::weight_addr(int'(layer_q), int'(node_q), int'(slot_q));
    b_addr   = mlpbp_pkg::BA_W'(int'(layer_q) * HW + int'(slot_q));
    in_addr  = node_q[mlpbp_pkg::IA_W-1:0];
    hid_addr = mlpbp_pkg::HA_W'((int'(layer_q) - 1) * HW + int'(node_q));
    w_wd     = mlpbp_pkg::sat_add(w_rd, mq);
    b_wd     = mlpbp_pkg::sat_add(b_rd, mq);
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_q)
      ST_IDLE: begin
        w_addr   = mlpbp_pkg::weight_addr(fl, fj, fs);
        b_addr   = mlpbp_pkg::BA_W'(fl * HW + fs);
        in_addr  = in_ch_i.node_index[mlpbp_pkg::IA_W-1:0];
        hid_addr = mlpbp_pkg::HA_W'((fl - 1) * HW + fj);
        w_wd     = in_ch_i.data_word;
        b_wd     = in_ch_i.data_word;
        if (in_acc) begin
          unique case (mlpbp_pkg::cmd_e'(in_ch_i.cmd))
            mlpbp_pkg::CMD_WR_WEIGHT: w_we = mlpbp_pkg::weight_ok(fl, fj, fs);
            mlpbp_pkg::CMD_WR_BIAS:   b_we = mlpbp_pkg::bias_ok(fl, fs);
            mlpbp_pkg::CMD_IN_ACT:    in_we = (fj < mlpbp_pkg::INPUT_WIDTH);
            mlpbp_pkg::CMD_HID_ACT:   hid_we = (fl >= 1) && (fl <= HL) && (fj < HW);
            default: ;
          endcase
        end
      end
      ST_T_Y0: begin
        mul_a = $signed({net_q[DW-1], net_q});
        mul_b = mlpbp_pkg::sat_sub(mlpbp_pkg::Q_ONE, net_q);
      end
      ST_T_Y2: begin
        mul_a = (mlpbp_pkg::OPA_W)'(mlpbp_pkg::sat_sub(target_q, net_q));
        mul_b = mq;
      end
      ST_W0, ST_B0: begin
        mul_a = step_op;
        mul_b = next_val;
      end
      ST_W1: begin
        mul_a = $signed({w_rd[DW-1], w_rd});
        mul_b = next_val;
      end
      ST_W2: begin
        mul_a = $signed({mq[DW-1], mq});
        mul_b = act_q;
      end
      ST_W4: w_we = 1'b1;
      ST_E0: begin
        mul_a = $signed({act_q[DW-1], act_q});
        mul_b = mlpbp_pkg::sat_sub(mlpbp_pkg::Q_ONE, act_q);
      end
      ST_E2: begin
        mul_a = (mlpbp_pkg::OPA_W)'(mlpbp_pkg::sat_acc(acc_q));
        mul_b = mq;
      end
      ST_B2: b_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      w_mem[w_addr] <= w_wd;
    end
    w_rd <= w_mem[w_addr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      b_mem[b_addr] <= b_wd;
    end
    b_rd <= b_mem[b_addr];
  end

  always_ff @(posedge clk_i) begin
    if (in_we) begin
      in_mem[in_addr] <= in_ch_i.data_word;
    end
    in_rd <= in_mem[in_addr];
  end

  always_ff @(posedge clk_i) begin
    if (hid_we) begin
      hid_mem[hid_addr] <= in_ch_i.data_word;
    end
    hid_rd <= hid_mem[hid_addr];
  end

  // payload registers of the training step
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      target_q <= in_ch_i.data_word;
    end
    if (state_q == ST_T_Y4) begin
      derr_q <= mq;
    end
    if (state_q == ST_N_ACT) begin
      acc_q <= '0;
    end else if (state_q == ST_W3) begin
      acc_q <= acc_q + mlpbp_pkg::ACC_W'(mq);
    end
    if (state_q == ST_N_CAP) begin
      act_q <= (layer_q == '0) ? in_rd : hid_rd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      layer_q     <= '0;
      node_q      <= '0;
      slot_q      <= '0;
      step_q      <= mlpbp_pkg::STEP_RESET;
      net_q       <= '0;
      err_q       <= '{default: '0};
      res_word_q  <= '0;
      res_done_q  <= 1'b0;
      rd_ok_q     <= 1'b0;
      rd_bias_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
      out_done_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        step_q <= cfg_i.step_size;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_word_q  <= res_word_q;
        out_done_q  <= res_done_q;
      end else if (out_valid_q && out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (mlpbp_pkg::cmd_e'(in_ch_i.cmd))
              mlpbp_pkg::CMD_NET_OUT: net_q <= in_ch_i.data_word;
              mlpbp_pkg::CMD_TRAIN:   state_q <= ST_T_Y0;
              mlpbp_pkg::CMD_RD_WEIGHT: begin
                rd_ok_q   <= mlpbp_pkg::weight_ok(fl, fj, fs);
                rd_bias_q <= 1'b0;
                state_q   <= ST_RD_WAIT;
              end
              mlpbp_pkg::CMD_RD_BIAS: begin
                rd_ok_q   <= mlpbp_pkg::bias_ok(fl, fs);
                rd_bias_q <= 1'b1;
                state_q   <= ST_RD_WAIT;
              end
              default: ;
            endcase
          end
        end
        ST_RD_WAIT: begin
          res_word_q <= !rd_ok_q ? '0 : (rd_bias_q ? b_rd : w_rd);
          res_done_q <= 1'b0;
          state_q    <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        ST_T_Y0: state_q <= ST_T_Y1;
        ST_T_Y1: state_q <= ST_T_Y2;
        ST_T_Y2: state_q <= ST_T_Y3;
        ST_T_Y3: state_q <= ST_T_Y4;
        ST_T_Y4: begin
          layer_q <= mlpbp_pkg::LAYER_W'(HL);
          node_q  <= '0;
          slot_q  <= '0;
          state_q <= ST_N_ACT;
        end
        ST_N_ACT: begin
          slot_q  <= '0;
          state_q <= ST_N_CAP;
        end
        ST_N_CAP: state_q <= ST_W0;
        ST_W0: state_q <= ST_W1;
        ST_W1: state_q <= ST_W2;
        ST_W2: state_q <= ST_W3;
        ST_W3: state_q <= ST_W4;
        ST_W4: begin
          if (!last_slot) begin
            slot_q  <= slot_q + 1'b1;
            state_q <= ST_W0;
          end else if (layer_q != '0) begin
            state_q <= ST_E0;
          end else if (last_node) begin
            slot_q  <= '0;
            state_q <= ST_B0;
          end else begin
            node_q  <= node_q + 1'b1;
            state_q <= ST_N_ACT;
          end
        end
        ST_E0: state_q <= ST_E1;
        ST_E1: state_q <= ST_E2;
        ST_E2: state_q <= ST_E3;
        ST_E3: state_q <= ST_E4;
        ST_E4: begin
          err_q[mlpbp_pkg::HA_W'((int'(layer_q) - 1) * HW + int'(node_q))] <= mq;
          if (last_node) begin
            slot_q  <= '0;
            state_q <= ST_B0;
          end else begin
            node_q  <= node_q + 1'b1;
            state_q <= ST_N_ACT;
          end
        end
        ST_B0: state_q <= ST_B1;
        ST_B1: state_q <= ST_B2;
        ST_B2: begin
          if (!last_slot) begin
            slot_q  <= slot_q + 1'b1;
            state_q <= ST_B0;
          end else if (layer_q == '0) begin
            res_word_q <= '0;
            res_done_q <= 1'b1;
            state_q    <= ST_OUT;
          end else begin
            layer_q <= layer_q - 1'b1;
            node_q  <= '0;
            state_q <= ST_N_ACT;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_CLKED(a_train_starts, clk_i, rst_ni, (in_acc && in_ch_i.cmd == mlpbp_pkg::CMD_TRAIN) |=> (state_q == ST_T_Y0), "train item did not start the sequencer")
  `ASSERT_CLKED(a_load_single, clk_i, rst_ni, (in_acc && (in_ch_i.cmd == mlpbp_pkg::CMD_WR_WEIGHT || in_ch_i.cmd == mlpbp_pkg::CMD_NET_OUT || in_ch_i.cmd == mlpbp_pkg::CMD_IN_ACT)) |=> in_ch_i.ready, "load item kept the block busy")
  `ASSERT_NEVER(a_slot_range, clk_i, rst_ni, (state_q != ST_IDLE) && (slot_q > fan_m1), "slot beyond layer fanout")
  `ASSERT_NEVER(a_node_range, clk_i, rst_ni, (state_q != ST_IDLE) && (node_q > nodes_m1), "node beyond layer size")

endmodule

[tb/mlp_backprop_weight_update_unit_test.sv]
// testbench for the weight update unit: table-driven and random items checked against a predictor
`timescale 1ns / 1ps
module mlp_backprop_weight_update_unit_test;

  typedef logic signed [mlpbp_pkg::DATA_W-1:0] word_t;

  typedef struct {
    word_t word;
    logic  done;
  } result_t;

  typedef struct {
    mlpbp_pkg::cmd_e cmd;
    int    layer;
    int    node;
    int    slot;
    word_t data;
    bit    typed;
    word_t exp_word;
    logic  exp_done;
  } row_t;

  localparam longint Q1   = longint'(1) << mlpbp_pkg::FRAC_BITS;
  localparam longint HALF = longint'(1) << (mlpbp_pkg::FRAC_BITS - 1);

  logic clk_i;
  logic rst_ni;

  mlpbp_in_if  in_ch ();
  mlpbp_out_if out_ch ();
  mlpbp_cfg_if cfg_ch ();

  mlp_backprop_weight_update_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch),
    .cfg_i   (cfg_ch)
  );

  // predictor state
  word_t            w_mem [mlpbp_pkg::W_DEPTH];
  word_t            b_mem [mlpbp_pkg::B_DEPTH];
  word_t            in_act [mlpbp_pkg::INPUT_WIDTH];
  word_t            hid_act [mlpbp_pkg::H_DEPTH];
  word_t            err_mem [mlpbp_pkg::H_DEPTH];
  word_t            net_y;
  logic [mlpbp_pkg::STEP_W-1:0] lr;

  result_t pending_results[$];
  int      errors;
  bit      calm;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic word_t sat32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return word_t'(v);
  endfunction

  function automatic word_t q_mul(input longint a, input longint b);
    return sat32((a * b + HALF) >>> mlpbp_pkg::FRAC_BITS);
  endfunction

  function automatic word_t q_add(input longint a, input longint b);
    return sat32(a + b);
  endfunction

  function automatic int fanout_of(input int l);
    return (l < mlpbp_pkg::HIDDEN_LAYERS) ? mlpbp_pkg::HIDDEN_WIDTH : 1;
  endfunction

  function automatic int nodes_of(input int l);
    return (l == 0) ? mlpbp_pkg::INPUT_WIDTH : mlpbp_pkg::HIDDEN_WIDTH;
  endfunction

  function automatic int w_index(input int l, input int j, input int s);
    int base;
    if (l > mlpbp_pkg::HIDDEN_LAYERS || j >= nodes_of(l) || s >= fanout_of(l)) return -1;
    base = (l == 0) ? 0 : mlpbp_pkg::INPUT_WIDTH * mlpbp_pkg::HIDDEN_WIDTH
                          + (l - 1) * mlpbp_pkg::HIDDEN_WIDTH * mlpbp_pkg::HIDDEN_WIDTH;
    return base + j * fanout_of(l) + s;
  endfunction

  function automatic int b_index(input int l, input int s);
    if (l > mlpbp_pkg::HIDDEN_LAYERS || s >= fanout_of(l)) return -1;
    return l * mlpbp_pkg::HIDDEN_WIDTH + s;
  endfunction

  // one sgd step, output node back to the input layer
  function automatic void backprop_step(input word_t target);
    word_t  delta [mlpbp_pkg::HIDDEN_WIDTH];
    word_t  y;
    word_t  act;
    longint acc;
    int     fan;
    int     base;
    int     hw;
    hw = mlpbp_pkg::HIDDEN_WIDTH;
    y = net_y;
    for (int s = 0; s < hw; s++) delta[s] = '0;
    delta[0] = q_mul(q_add(target, -longint'(y)), q_mul(y, q_add(Q1, -longint'(y))));
    for (int l = mlpbp_pkg::HIDDEN_LAYERS; l >= 0; l--) begin
      fan = fanout_of(l);
      if (l < mlpbp_pkg::HIDDEN_LAYERS)
        for (int s = 0; s < hw; s++) delta[s] = err_mem[l * hw + s];
      for (int j = 0; j < nodes_of(l); j++) begin
        base = w_index(l, j, 0);
        if (l > 0) begin
          acc = 0;
          for (int s = 0; s < fan; s++) acc += q_mul(w_mem[base + s], delta[s]);
          act = hid_act[(l - 1) * hw + j];
          err_mem[(l - 1) * hw + j] =
            q_mul(sat32(acc), q_mul(act, q_add(Q1, -longint'(act))));
        end else begin
          act = in_act[j];
        end
        for (int s = 0; s < fan; s++)
          w_mem[base + s] = q_add(w_mem[base + s], q_mul(q_mul(longint'(lr), delta[s]), act));
      end
      for (int s = 0; s < fan; s++)
        b_mem[l * hw + s] = q_add(b_mem[l * hw + s], q_mul(longint'(lr), delta[s]));
    end
  endfunction

  function automatic bit apply_item(input mlpbp_pkg::cmd_e c, input int l, input int j,
                                    input int s, input word_t d, output result_t r);
    int a;
    r.word = '0;
    r.done = 1'b0;
    case (c)
      mlpbp_pkg::CMD_WR_WEIGHT: begin
        a = w_index(l, j, s);
        if (a >= 0) w_mem[a] = d;
        return 0;
      end
      mlpbp_pkg::CMD_WR_BIAS: begin
        a = b_index(l, s);
        if (a >= 0) b_mem[a] = d;
        return 0;
      end
      mlpbp_pkg::CMD_IN_ACT: begin
        if (j < mlpbp_pkg::INPUT_WIDTH) in_act[j] = d;
        return 0;
      end
      mlpbp_pkg::CMD_HID_ACT: begin
        if (l >= 1 && l <= mlpbp_pkg::HIDDEN_LAYERS && j < mlpbp_pkg::HIDDEN_WIDTH)
          hid_act[(l - 1) * mlpbp_pkg::HIDDEN_WIDTH + j] = d;
        return 0;
      end
      mlpbp_pkg::CMD_NET_OUT: begin
        net_y = d;
        return 0;
      end
      mlpbp_pkg::CMD_TRAIN: begin
        backprop_step(d);
        r.done = 1'b1;
      end
      mlpbp_pkg::CMD_RD_WEIGHT: begin
        a = w_index(l, j, s);
        if (a >= 0) r.word = w_mem[a];
      end
      default: begin
        a = b_index(l, s);
        if (a >= 0) r.word = b_mem[a];
      end
    endcase
    return 1;
  endfunction

  task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
    $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
    errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, read_word", 0, out_ch.read_word);
      end else begin
        e = pending_results.pop_front();
        if (out_ch.read_word !== e.word) report_mismatch("read_word", e.word, out_ch.read_word);
        if (out_ch.train_done !== e.done) report_mismatch("train_done", e.done, out_ch.train_done);
      end
    end
  end

  always @(posedge clk_i) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 12);
  end

  task automatic send_item(input mlpbp_pkg::cmd_e c, input int l, input int j, input int s,
                           input word_t d, input bit typed, input word_t ew, input logic ed);
    result_t r;
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= c;
    in_ch.layer_index <= mlpbp_pkg::LAYER_FLD_W'(l);
    in_ch.node_index  <= mlpbp_pkg::NODE_FLD_W'(j);
    in_ch.target_slot <= mlpbp_pkg::SLOT_FLD_W'(s);
    in_ch.data_word   <= d;
    do @(posedge clk_i); while (!in_ch.ready);
    if (apply_item(c, l, j, s, d, r)) begin
      if (typed) begin
        r.word = ew;
        r.done = ed;
      end
      pending_results.push_back(r);
    end
    if (!calm && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // called at the accepting edge, so valid drops before another item slips in
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_step(input logic [mlpbp_pkg::STEP_W-1:0] v);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.step_size <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    lr = v;
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic word_t rand_word();
    if ($urandom_range(99) < 80) return word_t'($urandom_range(131072) - 65536);
    return word_t'($urandom);
  endfunction

  task automatic send_random();
    int   pick;
    int   l;
    int   j;
    int   s;
    mlpbp_pkg::cmd_e c;
    pick = $urandom_range(99);
    if (pick < 30) c = mlpbp_pkg::CMD_WR_WEIGHT;
    else if (pick < 40) c = mlpbp_pkg::CMD_WR_BIAS;
    else if (pick < 48) c = mlpbp_pkg::CMD_IN_ACT;
    else if (pick < 56) c = mlpbp_pkg::CMD_HID_ACT;
    else if (pick < 60) c = mlpbp_pkg::CMD_NET_OUT;
    else if (pick < 64) c = mlpbp_pkg::CMD_TRAIN;
    else if (pick < 84) c = mlpbp_pkg::CMD_RD_WEIGHT;
    else c = mlpbp_pkg::CMD_RD_BIAS;
    if ($urandom_range(99) < 20) begin
      // any address, often out of range
      l = $urandom_range(7);
      j = $urandom_range(63);
      s = $urandom_range(15);
    end else begin
      l = (c == mlpbp_pkg::CMD_HID_ACT) ? $urandom_range(mlpbp_pkg::HIDDEN_LAYERS, 1)
                                        : $urandom_range(mlpbp_pkg::HIDDEN_LAYERS);
      j = $urandom_range(nodes_of(l) - 1);
      s = $urandom_range(fanout_of(l) - 1);
    end
    send_item(c, l, j, s, rand_word(), 1'b0, '0, 1'b0);
  endtask

  initial begin
    row_t rows[$];
    logic [mlpbp_pkg::STEP_W-1:0] steps[4];
    errors = 0;
    calm   = 1'b0;
    lr     = mlpbp_pkg::STEP_RESET;
    net_y  = '0;
    foreach (err_mem[k]) err_mem[k] = '0;
    rst_ni             <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.cmd          <= mlpbp_pkg::CMD_WR_WEIGHT;
    in_ch.layer_index  <= '0;
    in_ch.node_index   <= '0;
    in_ch.target_slot  <= '0;
    in_ch.data_word    <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.step_size   <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill every store so no read or train sees an unwritten entry
    for (int l = 0; l <= mlpbp_pkg::HIDDEN_LAYERS; l++)
      for (int j = 0; j < nodes_of(l); j++)
        for (int s = 0; s < fanout_of(l); s++)
          send_item(mlpbp_pkg::CMD_WR_WEIGHT, l, j, s,
                    word_t'($urandom_range(65536) - 32768), 1'b0, '0, 1'b0);
    for (int l = 0; l <= mlpbp_pkg::HIDDEN_LAYERS; l++)
      for (int s = 0; s < fanout_of(l); s++)
        send_item(mlpbp_pkg::CMD_WR_BIAS, l, 0, s, word_t'($urandom_range(65536) - 32768),
                  1'b0, '0, 1'b0);
    for (int j = 0; j < mlpbp_pkg::INPUT_WIDTH; j++)
      send_item(mlpbp_pkg::CMD_IN_ACT, 0, j, 0, word_t'($urandom_range(65536)),
                1'b0, '0, 1'b0);
    for (int l = 1; l <= mlpbp_pkg::HIDDEN_LAYERS; l++)
      for (int j = 0; j < mlpbp_pkg::HIDDEN_WIDTH; j++)
        send_item(mlpbp_pkg::CMD_HID_ACT, l, j, 0, word_t'($urandom_range(65536)),
                  1'b0, '0, 1'b0);
    send_item(mlpbp_pkg::CMD_NET_OUT, 0, 0, 0, word_t'($urandom_range(65536)),
              1'b0, '0, 1'b0);

    // directed rows: extremes, bad addresses, ignored fields, every command
    rows = '{
      '{mlpbp_pkg::CMD_TRAIN,     0, 0,  0, 32'sh00010000, 1, 32'sh0,        1'b1},
      '{mlpbp_pkg::CMD_WR_WEIGHT, 0, 0,  0, 32'sh7fffffff, 0, 32'sh0,        1'b0},
      '{mlpbp_pkg::CMD_RD_WEIGHT, 0, 0,  0, 32'sh0,        1, 32'sh7fffffff, 1'b0},
      '{mlpbp_pkg::CMD_WR_WEIGHT, 2, 9,  0, 32'sh80000000, 0, 32'sh0,        1'b0},
      '{mlpbp_pkg::CMD_RD_WEIGHT, 2, 9,  0, 32'sh0,        1, 32'sh80000000, 1'b0},
      '{mlpbp_pkg::CMD_WR_WEIGHT, 7, 63, 15, 32'sh12345678, 0, 32'sh0,       1'b0},
      '{mlpbp_pkg::CMD_RD_WEIGHT, 3, 0,  0, 32'sh0,        1, 32'sh0,        1'b0},
      '{mlpbp_pkg::CMD_RD_WEIGHT, 2, 0,  1, 32'sh0,        1, 32'sh0,        1'b0},
      '{mlpbp_pkg::CMD_RD_WEIGHT, 1, 10, 0, 32'sh0,        1, 32'sh0,        1'b0},
      '{mlpbp_pkg::CMD_RD_WEIGHT, 0, 63, 9, 32'sh0,        0, 32'sh0,        1'b0},
      '{mlpbp_pkg::CMD_WR_BIAS,   2, 63, 0, 32'sh7fffffff, 0, 32'sh0,        1'b0},
      '{mlpbp_pkg::CMD_RD_BIAS,   2, 5,  0, 32'sh0,        1, 32'sh7fffffff, 1'b0},
      '{mlpbp_pkg::CMD_RD_BIAS,   0, 0,  10, 32'sh0,       1, 32'sh0,        1'b0},
      '{mlpbp_pkg::CMD_RD_BIAS,   2, 0,  1, 32'sh0,        1, 32'sh0,        1'b0},
      '{mlpbp_pkg::CMD_RD_BIAS,   7, 0,  15, 32'sh0,       1, 32'sh0,        1'b0},
      '{mlpbp_pkg::CMD_IN_ACT,    5, 63, 9, 32'sh00010000, 0, 32'sh0,        1'b0},
      '{mlpbp_pkg::CMD_HID_ACT,   0, 0,  0, 32'sh7fffffff, 0, 32'sh0,        1'b0},
      '{mlpbp_pkg::CMD_HID_ACT,   3, 0,  0, 32'sh80000000, 0, 32'sh0,        1'b0},
      '{mlpbp_pkg::CMD_HID_ACT,   1, 10, 0, 32'sh7fffffff, 0, 32'sh0,        1'b0},
      '{mlpbp_pkg::CMD_HID_ACT,   2, 9,  0, 32'sh00008000, 0, 32'sh0,        1'b0},
      '{mlpbp_pkg::CMD_NET_OUT,   7, 63, 15, 32'sh80000000, 0, 32'sh0,       1'b0},
      '{mlpbp_pkg::CMD_TRAIN,     7, 63, 15, 32'sh7fffffff, 1, 32'sh0,       1'b1},
      '{mlpbp_pkg::CMD_RD_WEIGHT, 0, 0,  0, 32'sh0,        0, 32'sh0,        1'b0},
      '{mlpbp_pkg::CMD_RD_BIAS,   1, 0,  9, 32'sh0,        0, 32'sh0,        1'b0}
    };
    foreach (rows[k])
      send_item(rows[k].cmd, rows[k].layer, rows[k].node, rows[k].slot, rows[k].data,
                rows[k].typed, rows[k].exp_word, rows[k].exp_done);

    steps = '{17'd0, 17'd65536, 17'($urandom_range(65536)), 17'd1};
    for (int k = 0; k < 600; k++) begin
      if (k % 150 == 0) begin
        wait_idle();
        write_step(steps[k / 150]);
      end
      calm = (k >= 300 && k < 400);
      send_random();
    end
    calm = 1'b0;
    wait_idle();
    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #12ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/mlpbp_pkg.sv
hw/rtl/mlpbp_if.sv
hw/rtl/mlpbp_qmul.sv
hw/rtl/mlp_backprop_weight_update_unit.sv
tb/mlp_backprop_weight_update_unit_test.sv
